[hw/rtl/object_persistence_tracker_macros.svh]
// Assertion macros for the tracker RTL, used by the table engine.
`ifndef OBJECT_PERSISTENCE_TRACKER_MACROS_SVH
`define OBJECT_PERSISTENCE_TRACKER_MACROS_SVH

// same-cycle implication
`define OPT_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OPT_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/opt_pkg.sv]
// Types and constants of the object persistence tracker.
`timescale 1ns / 1ps
`default_nettype none

package opt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int DWELL_W         = 18;
    localparam int CFG_AW          = 4;
    localparam int CFG_DW          = 32;

    localparam logic [1:0] REG_TOL_SQ      = 2'd0;
    localparam logic [1:0] REG_STABLE_TIME = 2'd1;
    localparam logic [1:0] REG_MAX_TIME    = 2'd2;

    localparam logic [19:0] TOL_SQ_RST      = 20'd400;
    localparam logic [15:0] STABLE_TIME_RST = 16'd2000;
    localparam logic [15:0] MAX_TIME_RST    = 16'd3000;

    typedef struct packed {
        logic              mode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [2:0]        class_id;
        logic [15:0]       time_delta;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic [2:0]        out_class;
        logic              is_empty;
        logic              is_last;
    } out_word_t;

    typedef struct packed {
        logic [19:0] tol_sq;
        logic [15:0] stable_time;
        logic [15:0] max_time;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [2:0]        cls;
    } pos_t;

endpackage

`default_nettype wire

[hw/rtl/opt_ram.sv]
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module opt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/opt_cfg.sv]
// APB-style register file for the tracker thresholds.
`timescale 1ns / 1ps
`default_nettype none

module opt_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [opt_pkg::CFG_AW-1:0]  paddr,
    input  logic [opt_pkg::CFG_DW-1:0]  pwdata,
    output logic [opt_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output opt_pkg::cfg_t               cfg
);

    import opt_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_TOL_SQ:      cfg_next.tol_sq      = pwdata[19:0];
                REG_STABLE_TIME: cfg_next.stable_time = pwdata[15:0];
                REG_MAX_TIME:    cfg_next.max_time    = pwdata[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TOL_SQ:      prdata = CFG_DW'(cfg_reg.tol_sq);
            REG_STABLE_TIME: prdata = CFG_DW'(cfg_reg.stable_time);
            REG_MAX_TIME:    prdata = CFG_DW'(cfg_reg.max_time);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tol_sq      <= TOL_SQ_RST;
            cfg_reg.stable_time <= STABLE_TIME_RST;
            cfg_reg.max_time    <= MAX_TIME_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[hw/rtl/opt_eng.sv]
// Table engine: match pipeline, ageing and compaction pass, report pass.
`timescale 1ns / 1ps
`default_nettype none
`include "object_persistence_tracker_macros.svh"

module opt_eng #(
    parameter int DEPTH = opt_pkg::TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  opt_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  opt_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output opt_pkg::out_word_t out_word
);

    import opt_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $bits(pos_t);
    localparam int DW = DWELL_W;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DET_SCAN  = 4'd1;
    localparam logic [3:0] ST_DET_DRAIN = 4'd2;
    localparam logic [3:0] ST_DET_FIN   = 4'd3;
    localparam logic [3:0] ST_EOF_SCAN  = 4'd4;
    localparam logic [3:0] ST_EOF_DRAIN = 4'd5;
    localparam logic [3:0] ST_REP_RD    = 4'd6;
    localparam logic [3:0] ST_REP_EV    = 4'd7;
    localparam logic [3:0] ST_REP_END   = 4'd8;

    function automatic logic [15:0] abs_diff(logic signed [15:0] a, logic signed [15:0] b);
        logic signed [16:0] d;
        d = {a[15], a} - {b[15], b};
        return d[16] ? 16'(-d) : d[15:0];
    endfunction

    function automatic out_word_t mk_out(pos_t p, logic last);
        out_word_t o;
        o.out_x     = p.x;
        o.out_y     = p.y;
        o.out_z     = p.z;
        o.out_class = p.cls;
        o.is_empty  = 1'b0;
        o.is_last   = last;
        return o;
    endfunction

    // control
    logic [3:0]       state_reg, state_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [CW-1:0]    rd_cnt_reg, rd_cnt_next;
    logic [CW-1:0]    w_cnt_reg, w_cnt_next;
    logic [DEPTH-1:0] seen_reg, seen_next;
    logic             matched_reg, matched_next;
    logic             p1_v_reg, p1_v_next;
    logic             p2_v_reg, p2_v_next;
    logic             p3_v_reg, p3_v_next;
    logic             c1_v_reg, c1_v_next;
    logic             pend_v_reg, pend_v_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    in_word_t              det_reg;
    logic [IW-1:0]         p1_idx_reg, p2_idx_reg, p3_idx_reg, c1_idx_reg;
    logic [15:0]           p2_ax_reg, p2_ay_reg, p2_az_reg;
    logic signed [DW-1:0]  p2_dwell_reg, p3_dwell_reg;
    logic [31:0]           p3_sx_reg, p3_sy_reg, p3_sz_reg;
    pos_t                  pend_reg, pend_next;
    out_word_t             out_word_reg, out_word_next;

    // memories
    logic                 pos_we, dwell_we;
    logic [IW-1:0]        pos_waddr, dwell_waddr;
    pos_t                 pos_wdata, pos_rd;
    logic signed [DW-1:0] dwell_wdata, dwell_rd;
    logic [PW-1:0]        pos_rd_raw;
    logic [DW-1:0]        dwell_rd_raw;

    logic                 accept;
    logic                 slot_free;
    logic                 last_issue;
    logic signed [DW-1:0] dt_s;
    logic [33:0]          dist_sq;
    logic                 hit;
    logic signed [DW-1:0] dwell_inc;
    logic                 below_cap;
    logic signed [DW-1:0] aged;
    logic                 keep;
    logic                 stable;
    pos_t                 det_pos;
    out_word_t            empty_word;

    opt_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (rd_cnt_reg[IW-1:0]),
        .rdata (pos_rd_raw)
    );

    opt_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_dwell_ram (
        .clk   (clk),
        .we    (dwell_we),
        .waddr (dwell_waddr),
        .wdata (dwell_wdata),
        .raddr (rd_cnt_reg[IW-1:0]),
        .rdata (dwell_rd_raw)
    );

    assign pos_rd   = pos_t'(pos_rd_raw);
    assign dwell_rd = $signed(dwell_rd_raw);

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign slot_free  = !out_valid_reg || !out_stall;
    assign last_issue = ((rd_cnt_reg + CW'(1)) == n_reg);
    assign dt_s       = $signed({{(DW-16){1'b0}}, det_reg.time_delta});

    // match stage
    assign dist_sq   = 34'(p3_sx_reg) + 34'(p3_sy_reg) + 34'(p3_sz_reg);
    assign hit       = p3_v_reg && (dist_sq < 34'(cfg.tol_sq));
    assign dwell_inc = p3_dwell_reg + dt_s;
    assign below_cap = p3_dwell_reg <= $signed({{(DW-16){1'b0}}, cfg.max_time});

    // ageing
    assign aged = seen_reg[c1_idx_reg] ? dwell_rd : dwell_rd - dt_s;
    assign keep = !aged[DW-1];

    assign stable = dwell_rd > $signed({{(DW-16){1'b0}}, cfg.stable_time});

    assign det_pos.x   = det_reg.pos_x;
    assign det_pos.y   = det_reg.pos_y;
    assign det_pos.z   = det_reg.pos_z;
    assign det_pos.cls = det_reg.class_id;

    assign empty_word = '{out_x: '0, out_y: '0, out_z: '0, out_class: '0,
                          is_empty: 1'b1, is_last: 1'b1};

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        rd_cnt_next    = rd_cnt_reg;
        w_cnt_next     = w_cnt_reg;
        seen_next      = seen_reg;
        matched_next   = matched_reg;
        p1_v_next      = 1'b0;
        p2_v_next      = p1_v_reg;
        p3_v_next      = p2_v_reg;
        c1_v_next      = 1'b0;
        pend_v_next    = pend_v_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        pos_we         = 1'b0;
        pos_waddr      = w_cnt_reg[IW-1:0];
        pos_wdata      = pos_rd;
        dwell_we       = 1'b0;
        dwell_waddr    = w_cnt_reg[IW-1:0];
        dwell_wdata    = aged;

        if (hit)
        begin
            seen_next[p3_idx_reg] = 1'b1;
            matched_next          = 1'b1;
            dwell_we              = below_cap;
            dwell_waddr           = p3_idx_reg;
            dwell_wdata           = dwell_inc;
        end

        // compaction: survivors close up towards the front
        if (c1_v_reg && keep)
        begin
            pos_we     = 1'b1;
            dwell_we   = 1'b1;
            w_cnt_next = w_cnt_reg + CW'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_cnt_next  = '0;
                    w_cnt_next   = '0;
                    matched_next = 1'b0;
                    if (!in_word.mode)
                    begin
                        state_next = (n_reg == '0) ? ST_DET_FIN : ST_DET_SCAN;
                    end
                    else
                    begin
                        state_next = (n_reg == '0) ? ST_EOF_DRAIN : ST_EOF_SCAN;
                    end
                end
            end
            ST_DET_SCAN:
            begin
                p1_v_next   = 1'b1;
                rd_cnt_next = rd_cnt_reg + CW'(1);
                if (last_issue)
                begin
                    state_next = ST_DET_DRAIN;
                end
            end
            ST_DET_DRAIN:
            begin
                if (!p1_v_reg && !p2_v_reg && !p3_v_reg)
                begin
                    state_next = ST_DET_FIN;
                end
            end
            ST_DET_FIN:
            begin
                if (!matched_reg && (n_reg < CW'(DEPTH)))
                begin
                    pos_we                   = 1'b1;
                    pos_waddr                = n_reg[IW-1:0];
                    pos_wdata                = det_pos;
                    dwell_we                 = 1'b1;
                    dwell_waddr              = n_reg[IW-1:0];
                    dwell_wdata              = '0;
                    seen_next[n_reg[IW-1:0]] = 1'b1;
                    n_next                   = n_reg + CW'(1);
                end
                state_next = ST_IDLE;
            end
            ST_EOF_SCAN:
            begin
                c1_v_next   = 1'b1;
                rd_cnt_next = rd_cnt_reg + CW'(1);
                if (last_issue)
                begin
                    state_next = ST_EOF_DRAIN;
                end
            end
            ST_EOF_DRAIN:
            begin
                if (!c1_v_reg)
                begin
                    n_next      = w_cnt_reg;
                    seen_next   = '0;
                    rd_cnt_next = '0;
                    state_next  = (w_cnt_reg == '0) ? ST_REP_END : ST_REP_RD;
                end
            end
            ST_REP_RD:
            begin
                state_next = ST_REP_EV;
            end
            ST_REP_EV:
            begin
                // one stable entry is held back until the next shows whether it is last
                if (!stable || !pend_v_reg || slot_free)
                begin
                    if (stable)
                    begin
                        if (pend_v_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_word_next  = mk_out(pend_reg, 1'b0);
                        end
                        pend_v_next = 1'b1;
                        pend_next   = pos_rd;
                    end
                    rd_cnt_next = rd_cnt_reg + CW'(1);
                    state_next  = last_issue ? ST_REP_END : ST_REP_RD;
                end
            end
            ST_REP_END:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = pend_v_reg ? mk_out(pend_reg, 1'b1) : empty_word;
                    pend_v_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            rd_cnt_reg    <= '0;
            w_cnt_reg     <= '0;
            seen_reg      <= '0;
            matched_reg   <= 1'b0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            p3_v_reg      <= 1'b0;
            c1_v_reg      <= 1'b0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            rd_cnt_reg    <= rd_cnt_next;
            w_cnt_reg     <= w_cnt_next;
            seen_reg      <= seen_next;
            matched_reg   <= matched_next;
            p1_v_reg      <= p1_v_next;
            p2_v_reg      <= p2_v_next;
            p3_v_reg      <= p3_v_next;
            c1_v_reg      <= c1_v_next;
            pend_v_reg    <= pend_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            det_reg <= in_word;
        end
        p1_idx_reg   <= rd_cnt_reg[IW-1:0];
        c1_idx_reg   <= rd_cnt_reg[IW-1:0];
        p2_idx_reg   <= p1_idx_reg;
        p2_ax_reg    <= abs_diff(pos_rd.x, det_reg.pos_x);
        p2_ay_reg    <= abs_diff(pos_rd.y, det_reg.pos_y);
        p2_az_reg    <= abs_diff(pos_rd.z, det_reg.pos_z);
        p2_dwell_reg <= dwell_rd;
        p3_idx_reg   <= p2_idx_reg;
        p3_sx_reg    <= p2_ax_reg * p2_ax_reg;
        p3_sy_reg    <= p2_ay_reg * p2_ay_reg;
        p3_sz_reg    <= p2_az_reg * p2_az_reg;
        p3_dwell_reg <= p2_dwell_reg;
        pend_reg     <= pend_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `OPT_CHECK(a_fill_bound, 1'b1, n_reg <= CW'(DEPTH), "fill count beyond table depth")

    `OPT_CHECK_NEXT(a_append_grows,
        (state_reg == ST_DET_FIN) && !matched_reg && (n_reg < CW'(DEPTH)),
        n_reg == $past(n_reg) + CW'(1), "unmatched detection not appended")

    `OPT_CHECK(a_compact_order, c1_v_reg, w_cnt_reg <= CW'(c1_idx_reg),
        "compaction write pointer ahead of read position")

    `OPT_CHECK_NEXT(a_seen_cleared, (state_reg == ST_REP_END) && slot_free,
        seen_reg == '0, "seen marks survive the end of frame")

endmodule

`default_nettype wire

[hw/rtl/object_persistence_tracker.sv]
// Top level of the object persistence tracker.
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to TABLE_DEPTH tracked objects in two single-port-read RAMs
// (position/class and dwell) with a fill count; no clearing pass follows
// reset. One word is taken at a time, and the input is stalled while it is
// worked on. A detection word streams the valid entries through a read,
// difference, square and compare pipeline that writes the updated dwell back.
// An end-of-frame word runs an ageing and compaction pass, then a report
// pass over the surviving entries through the same RAM read port and a
// closing step, both of which an output stall can hold; the last report
// word is marked is_last, and a frame with nothing stable gives one word
// with is_empty set. A finished report word waits in the output register
// while the next input word is taken.
module object_persistence_tracker #(
    parameter int TABLE_DEPTH = opt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [opt_pkg::CFG_AW-1:0] paddr,
    input  logic [opt_pkg::CFG_DW-1:0] pwdata,
    output logic [opt_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  opt_pkg::in_word_t          in_word,
    output logic                       out_valid,
    input  logic                       out_stall,
    output opt_pkg::out_word_t         out_word
);

    import opt_pkg::*;

    cfg_t cfg;

    opt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    opt_eng #(.DEPTH(TABLE_DEPTH)) u_eng (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

[tb/sv/object_persistence_tracker_test.sv]
// Self-checking testbench for the object persistence tracker: predictor, driver, monitor.
`timescale 1ns / 1ps

module object_persistence_tracker_test;

    import opt_pkg::*;

    localparam int          DEPTH        = TABLE_DEPTH_DEF;
    localparam logic        MODE_DETECT  = 1'b0;
    localparam logic        MODE_FRAME   = 1'b1;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          PRINT_CAP    = 40;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [CFG_AW-1:0]   paddr     = '0;
    logic [CFG_DW-1:0]   pwdata    = '0;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    in_word_t            in_word   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_word_t           out_word;

    object_persistence_tracker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // tracker copy kept by the testbench
    logic [19:0]        cfg_tol    = TOL_SQ_RST;
    logic [15:0]        cfg_stable = STABLE_TIME_RST;
    logic [15:0]        cfg_max    = MAX_TIME_RST;
    pos_t               trk_pos   [DEPTH];
    logic signed [17:0] trk_dwell [DEPTH];
    logic               trk_valid [DEPTH];
    logic               trk_seen  [DEPTH];

    in_word_t  word_q  [$];
    out_word_t report_q[$];

    logic in_took = 1'b0;
    int   gap_left = 0;
    int   burst_left = 0;
    bit   hold_req = 1'b0;
    int   hold_done = 0;
    int   seg_left = 0;
    int   stall_kind = 0;
    int   cycles = 0;

    int mismatches = 0;
    int n_words = 0;
    int n_frames = 0;
    int n_results = 0;
    int n_stable = 0;
    int n_dropped = 0;
    int n_capped = 0;
    int n_phases = 0;

    function automatic void track_clear();
        for (int i = 0; i < DEPTH; i++)
        begin
            trk_pos[i]   = '0;
            trk_dwell[i] = '0;
            trk_valid[i] = 1'b0;
            trk_seen[i]  = 1'b0;
        end
    endfunction

    function automatic void track_word(in_word_t w);
        int         slot;
        int         wr;
        int         last_ix;
        bit         hit;
        longint     dx;
        longint     dy;
        longint     dz;
        out_word_t  r;
        if (w.mode == MODE_DETECT)
        begin
            slot = -1;
            hit  = 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (!trk_valid[i])
                begin
                    if (slot < 0)
                        slot = i;
                end
                else
                begin
                    dx = longint'($signed(trk_pos[i].x)) - longint'($signed(w.pos_x));
                    dy = longint'($signed(trk_pos[i].y)) - longint'($signed(w.pos_y));
                    dz = longint'($signed(trk_pos[i].z)) - longint'($signed(w.pos_z));
                    if (dx * dx + dy * dy + dz * dz < longint'(cfg_tol))
                    begin
                        if (trk_dwell[i] <= $signed({2'b00, cfg_max}))
                            trk_dwell[i] = trk_dwell[i] + $signed({2'b00, w.time_delta});
                        else
                            n_capped++;
                        trk_seen[i] = 1'b1;
                        hit = 1'b1;
                    end
                end
            end
            if (!hit && slot >= 0)
            begin
                trk_pos[slot]   = '{x: w.pos_x, y: w.pos_y, z: w.pos_z, cls: w.class_id};
                trk_dwell[slot] = '0;
                trk_valid[slot] = 1'b1;
                trk_seen[slot]  = 1'b1;
            end
            else if (!hit)
                n_dropped++;
            return;
        end

        // frame end: age unseen, free expired, close up
        n_frames++;
        wr = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (trk_valid[i])
            begin
                if (!trk_seen[i])
                    trk_dwell[i] = trk_dwell[i] - $signed({2'b00, w.time_delta});
                if (trk_dwell[i] >= 0)
                begin
                    trk_pos[wr]   = trk_pos[i];
                    trk_dwell[wr] = trk_dwell[i];
                    trk_seen[wr]  = trk_seen[i];
                    trk_valid[wr] = 1'b1;
                    wr++;
                end
            end
        end
        for (int i = wr; i < DEPTH; i++)
        begin
            trk_valid[i] = 1'b0;
            trk_seen[i]  = 1'b0;
        end
        last_ix = -1;
        for (int i = 0; i < wr; i++)
            if (trk_dwell[i] > $signed({2'b00, cfg_stable}))
                last_ix = i;
        for (int i = 0; i < wr; i++)
        begin
            if (trk_dwell[i] > $signed({2'b00, cfg_stable}))
            begin
                r = '{out_x: trk_pos[i].x, out_y: trk_pos[i].y, out_z: trk_pos[i].z,
                      out_class: trk_pos[i].cls, is_empty: 1'b0, is_last: (i == last_ix)};
                report_q = {report_q, r};
            end
        end
        if (last_ix < 0)
        begin
            r = '0;
            r.is_empty = 1'b1;
            r.is_last  = 1'b1;
            report_q = {report_q, r};
        end
        for (int i = 0; i < DEPTH; i++)
            trk_seen[i] = 1'b0;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endfunction

    // input word driver, fed from word_q
    always @(negedge clk)
    begin : drive
        logic     nxt_valid;
        in_word_t nxt_word;
        nxt_valid = in_valid;
        nxt_word  = in_word;
        if (!in_valid || in_took)
        begin
            nxt_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (word_q.size() > 0)
            begin
                nxt_word  = word_q.pop_front();
                nxt_valid = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        in_valid <= nxt_valid;
        in_word  <= nxt_word;
    end

    // receiver stall pattern, plus one long hold-off
    always @(negedge clk)
    begin : recv
        if (hold_req && hold_done < HOLD_CYCLES)
        begin
            hold_done++;
            out_stall <= 1'b1;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_left   = $urandom_range(20, 80);
                stall_kind = $urandom_range(0, 3);
            end
            else
                seg_left--;
            case (stall_kind)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= (seg_left % 3 == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : watch
        out_word_t want;
        if (!rst_n)
            in_took <= 1'b0;
        else
        begin
            in_took <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                track_word(in_word);
                n_words++;
            end
            if (out_valid && !out_stall)
            begin
                if (report_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= PRINT_CAP)
                        $display("%0t: result word expected none got %h", $time, out_word);
                end
                else
                begin
                    want = report_q.pop_front();
                    n_results++;
                    if (!want.is_empty)
                        n_stable++;
                    check_field("out_x", want.out_x, out_word.out_x);
                    check_field("out_y", want.out_y, out_word.out_y);
                    check_field("out_z", want.out_z, out_word.out_z);
                    check_field("out_class", want.out_class, out_word.out_class);
                    check_field("is_empty", want.is_empty, out_word.is_empty);
                    check_field("is_last", want.is_last, out_word.is_last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL object_persistence_tracker");
            $finish;
        end
    end

    function automatic void push_detect(int x, int y, int z, int cls, int dt);
        in_word_t w;
        w.mode       = MODE_DETECT;
        w.pos_x      = x[15:0];
        w.pos_y      = y[15:0];
        w.pos_z      = z[15:0];
        w.class_id   = cls[2:0];
        w.time_delta = dt[15:0];
        word_q = {word_q, w};
    endfunction

    function automatic void push_frame_end(int dt);
        in_word_t w;
        w            = '0;
        w.mode       = MODE_FRAME;
        w.time_delta = dt[15:0];
        word_q = {word_q, w};
    endfunction

    function automatic int rand_delta(int typical);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 65535);
        return $urandom_range(0, typical);
    endfunction

    // scenes of objects seen over several frames with jitter, plus stray words
    function automatic void add_scenes(int budget, bit fill_table);
        int sx  [DEPTH + 2];
        int sy  [DEPTH + 2];
        int sz  [DEPTH + 2];
        int sc  [DEPTH + 2];
        int jit;
        int nobj;
        int nfr;
        int added;
        added = 0;
        jit = 0;
        while (jit < 200 && 3 * (jit + 1) * (jit + 1) < int'(cfg_tol))
            jit++;
        while (added < budget)
        begin
            nobj = fill_table ? DEPTH + 2 : $urandom_range(1, 6);
            nfr  = fill_table ? 2 : $urandom_range(2, 6);
            fill_table = 1'b0;
            for (int o = 0; o < nobj; o++)
            begin
                sx[o] = int'($urandom_range(0, 64000)) - 32000;
                sy[o] = int'($urandom_range(0, 64000)) - 32000;
                sz[o] = int'($urandom_range(0, 64000)) - 32000;
                sc[o] = $urandom_range(0, 7);
            end
            for (int f = 0; f < nfr; f++)
            begin
                for (int o = 0; o < nobj; o++)
                begin
                    if ($urandom_range(0, 9) < 8)
                    begin
                        push_detect(sx[o] + int'($urandom_range(0, 2 * jit)) - jit,
                                    sy[o] + int'($urandom_range(0, 2 * jit)) - jit,
                                    sz[o] + int'($urandom_range(0, 2 * jit)) - jit,
                                    sc[o], rand_delta(1200));
                        added++;
                    end
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    push_detect($urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 65535), $urandom_range(0, 7),
                                $urandom_range(0, 65535));
                    added++;
                end
                push_frame_end(rand_delta(600));
                added++;
            end
        end
    endfunction

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_TOL_SQ:      cfg_tol    = val[19:0];
            REG_STABLE_TIME: cfg_stable = val[15:0];
            REG_MAX_TIME:    cfg_max    = val[15:0];
            default:         ;
        endcase
        if (rd !== val)
        begin
            mismatches++;
            $display("%0t: register %0d readback expected %h got %h", $time, idx, val, rd);
        end
    endtask

    task automatic wait_drain();
        while (word_q.size() > 0 || in_valid || report_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        n_phases++;
    endtask

    initial
    begin : stim
        int st;
        track_clear();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset settings
        push_frame_end(5);                          // empty table
        push_detect(0, 0, 0, 7, 0);                 // A
        push_detect(32767, -32768, 32767, 0, 0);    // B at the corner
        push_detect(-32768, 32767, -32768, 5, 0);   // C at the opposite corner
        push_frame_end(0);                          // nothing stable yet
        push_detect(5, 5, 5, 1, 2500);
        push_detect(32760, -32761, 32760, 6, 3000);
        push_detect(32767, -32768, 32767, 6, 10);   // dwell exactly at the cap
        push_frame_end(1);                          // C goes negative
        push_detect(1, 1, 1, 2, 65535);
        push_detect(0, 0, 0, 2, 100);               // above the cap, no gain
        push_detect(20, 0, 0, 3, 9);                // distance equal to tolerance
        push_detect(100, 0, 0, 2, 0);
        push_detect(130, 0, 0, 4, 0);
        push_detect(115, 0, 0, 1, 3001);            // matches two entries
        push_frame_end(3011);                       // frees B in the middle
        push_frame_end(65535);
        push_frame_end(2500);                       // dwell lands on zero
        push_frame_end(1);
        add_scenes(45, 1'b1);
        wait_drain();

        cfg_write(REG_TOL_SQ, 32'd1000000);
        cfg_write(REG_STABLE_TIME, 32'd0);
        cfg_write(REG_MAX_TIME, 32'd65535);
        add_scenes(30, 1'b0);
        wait_drain();

        cfg_write(REG_TOL_SQ, 32'd0);
        cfg_write(REG_STABLE_TIME, 32'd65535);
        cfg_write(REG_MAX_TIME, 32'd0);
        add_scenes(20, 1'b0);
        wait_drain();

        st = $urandom_range(200, 3000);
        cfg_write(REG_TOL_SQ, $urandom_range(100, 5000));
        cfg_write(REG_STABLE_TIME, st);
        cfg_write(REG_MAX_TIME, st + $urandom_range(0, 3000));
        hold_req = 1'b1;
        add_scenes(40, 1'b0);
        wait_drain();

        cfg_write(REG_TOL_SQ, TOL_SQ_RST);
        cfg_write(REG_STABLE_TIME, STABLE_TIME_RST);
        cfg_write(REG_MAX_TIME, MAX_TIME_RST);
        add_scenes(20, 1'b0);
        wait_drain();

        $display("Run: %0d words over %0d settings, %0d frame ends, %0d result words (%0d stable)",
                 n_words, n_phases, n_frames, n_results, n_stable);
        $display("Run: %0d detections dropped on a full table, %0d matches held at the cap",
                 n_dropped, n_capped);
        if (mismatches == 0)
            $display("PASS object_persistence_tracker");
        else
            $display("FAIL object_persistence_tracker");
        $finish;
    end

endmodule
